@@ rtl/core/dwo_pkg.sv @@
// Package for the differential wheel odometry block: widths, register indexes,
// result slots, sequencer types and the shared rounding helper.
// Depends on nothing; the core takes everything by scoped names.
package dwo_pkg;

   // Encoder and window geometry.
   localparam int ENCODER_COUNTS = 16384;
   localparam int COUNT_W        = $clog2(ENCODER_COUNTS);
   localparam int HALF_COUNTS    = ENCODER_COUNTS / 2;
   localparam int DIFF_W         = COUNT_W + 2;
   localparam int CC_W           = COUNT_W + 1;

   // The window length must stay a power of two: the mean is a rounded shift.
   localparam int WINDOW_LENGTH  = 8;
   localparam int WIN_BITS       = $clog2(WINDOW_LENGTH);

   localparam int OUT_W          = 32;
   localparam int SUM_W          = OUT_W + WIN_BITS;
   localparam int ANGLE_W        = 19;
   localparam int OPA_W          = OUT_W + 1;
   localparam int PROD_W         = OPA_W + OUT_W;
   localparam int RND_W          = PROD_W + 1;

   localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(HALF_COUNTS);
   localparam logic signed [DIFF_W-1:0] ENC_S  = DIFF_W'(ENCODER_COUNTS);

   // Two pi in Q32, split so that the shared multiplier sees a 32-bit operand.
   localparam logic [35:0]       TWO_PI_Q32 = 36'd26986075409;
   localparam logic [OUT_W-1:0]  ANGLE_LO   = TWO_PI_Q32[31:0];
   localparam logic [3:0]        ANGLE_HI   = TWO_PI_Q32[35:32];

   localparam int SPEED_SHIFT = 8;
   localparam int Q24_SHIFT   = 24;
   localparam int BODY_SHIFT  = 1;
   localparam int ANGLE_SHIFT = COUNT_W + 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_REV    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_REV     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_PER_CNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RPM_PER_CNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TRACK    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RPM_PER_VEL  = 3'd5;

   // Result slots, in the order of the result word.
   localparam int NUM_RESULTS = 12;
   localparam int SLOT_W      = 4;
   localparam logic [SLOT_W-1:0] SLOT_BODY          = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT_SPEED   = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_LEFT_SPEED    = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT_AVG     = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_LEFT_AVG      = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT_RPM     = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_LEFT_RPM      = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT_RPM_AVG = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_LEFT_RPM_AVG  = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_YAW           = 4'd9;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT_ANGLE   = 4'd10;
   localparam logic [SLOT_W-1:0] SLOT_LEFT_ANGLE    = 4'd11;

   // Sequencer steps. Step n issues operation n-1 to the multiplier and
   // rounds the product of operation n-2.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ISSUE  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_POST   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_WINDOW = 4'd4;
   localparam logic [STEP_W-1:0] STEP_AVG    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LAST   = 4'd11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_RIGHT_SPEED,
      OP_LEFT_SPEED,
      OP_RIGHT_RPM,
      OP_LEFT_RPM,
      OP_BODY,
      OP_YAW,
      OP_RIGHT_RPM_AVG,
      OP_LEFT_RPM_AVG,
      OP_RIGHT_ANGLE,
      OP_LEFT_ANGLE
   } op_type;

   function automatic logic [SLOT_W-1:0] op_slot(op_type op);
      logic [SLOT_W-1:0] slot;
      case (op)
         OP_RIGHT_SPEED:   slot = SLOT_RIGHT_SPEED;
         OP_LEFT_SPEED:    slot = SLOT_LEFT_SPEED;
         OP_RIGHT_RPM:     slot = SLOT_RIGHT_RPM;
         OP_LEFT_RPM:      slot = SLOT_LEFT_RPM;
         OP_BODY:          slot = SLOT_BODY;
         OP_YAW:           slot = SLOT_YAW;
         OP_RIGHT_RPM_AVG: slot = SLOT_RIGHT_RPM_AVG;
         OP_LEFT_RPM_AVG:  slot = SLOT_LEFT_RPM_AVG;
         OP_RIGHT_ANGLE:   slot = SLOT_RIGHT_ANGLE;
         OP_LEFT_ANGLE:    slot = SLOT_LEFT_ANGLE;
         default:          slot = SLOT_BODY;
      endcase
      return slot;
   endfunction

   // Round half away from zero on the magnitude, by the shift of the operation.
   function automatic logic [RND_W-1:0] round_mag(op_type op, logic [PROD_W-1:0] mag);
      logic [RND_W-1:0] x;
      logic [RND_W-1:0] r;
      x = RND_W'(mag);
      case (op)
         OP_RIGHT_SPEED, OP_LEFT_SPEED, OP_RIGHT_RPM, OP_LEFT_RPM:
            r = (x + (RND_W'(1) << (SPEED_SHIFT - 1))) >> SPEED_SHIFT;
         OP_BODY:
            r = (x + (RND_W'(1) << (BODY_SHIFT - 1))) >> BODY_SHIFT;
         OP_YAW, OP_RIGHT_RPM_AVG, OP_LEFT_RPM_AVG:
            r = (x + (RND_W'(1) << (Q24_SHIFT - 1))) >> Q24_SHIFT;
         OP_RIGHT_ANGLE, OP_LEFT_ANGLE:
            r = (x + (RND_W'(1) << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
         default:
            r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/differential_wheel_odometry.sv @@
// Differential-drive wheel odometry core: one shared multiplier and rounding
// unit stepped by a small sequencer. Depends on dwo_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  right and left encoder counts
//   rsp      out        rsp_valid/rsp_ready  speeds, rpm, averages, yaw, angles
//   csr      in         csr_valid/csr_ready  register index and write data
//
// After acceptance a word runs through the sequencer steps, then moves into the
// output register; no new word is taken before that move. The single multiplier,
// used once for each of the ten products, sets the pace of a word.
// Synchronous reset clears the configuration, previous counts, speed window,
// window sums and the handshake state; no clearing pass is needed.
// A new request word is taken while a finished result still waits in the
// output register; a stalled result only holds the sequencer at its end.
// The configuration port is always ready.
module differential_wheel_odometry (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dwo_pkg::COUNT_W-1:0]           req_right_count,
   input  logic [dwo_pkg::COUNT_W-1:0]           req_left_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_body_speed,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_right_speed,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_left_speed,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_right_speed_avg,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_left_speed_avg,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_right_rpm,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_left_rpm,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_right_rpm_avg,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_left_rpm_avg,
   output logic signed [dwo_pkg::OUT_W-1:0]      rsp_yaw_rate,
   output logic [dwo_pkg::ANGLE_W-1:0]           rsp_right_angle,
   output logic [dwo_pkg::ANGLE_W-1:0]           rsp_left_angle,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dwo_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dwo_pkg::OUT_W-1:0]             csr_data
);

   // Configuration registers.
   logic                          right_rev_ff;
   logic                          left_rev_ff;
   logic [dwo_pkg::OUT_W-1:0]     vel_per_cnt_ff;
   logic [dwo_pkg::OUT_W-1:0]     rpm_per_cnt_ff;
   logic [dwo_pkg::OUT_W-1:0]     inv_track_ff;
   logic [dwo_pkg::OUT_W-1:0]     rpm_per_vel_ff;

   // Sequencer and handshake.
   dwo_pkg::state_type            state_ff, state_in;
   logic [dwo_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          copy_out;
   logic                          req_take;

   // Sample state.
   logic [dwo_pkg::COUNT_W-1:0]   cnt_r_ff, cnt_l_ff;
   logic [dwo_pkg::COUNT_W-1:0]   prev_r_ff, prev_l_ff;
   logic [dwo_pkg::COUNT_W-1:0]   dmag_r_ff, dmag_l_ff;
   logic                          neg_r_ff, neg_l_ff;

   logic signed [dwo_pkg::OUT_W-1:0] win_r_ff [dwo_pkg::WINDOW_LENGTH];
   logic signed [dwo_pkg::OUT_W-1:0] win_l_ff [dwo_pkg::WINDOW_LENGTH];
   logic signed [dwo_pkg::SUM_W-1:0] sum_r_ff, sum_l_ff;
   logic [dwo_pkg::WIN_BITS-1:0]     pos_ff;

   logic [dwo_pkg::OPA_W-1:0]     vsum_mag_ff, vdif_mag_ff;
   logic                          vsum_neg_ff, vdif_neg_ff;
   logic [dwo_pkg::OUT_W-1:0]     avg_mag_r_ff, avg_mag_l_ff;
   logic                          avg_neg_r_ff, avg_neg_l_ff;

   // Shared multiplier.
   logic [dwo_pkg::OPA_W-1:0]     mul_a;
   logic [dwo_pkg::OUT_W-1:0]     mul_b;
   logic [dwo_pkg::PROD_W-1:0]    mul_add;
   logic [dwo_pkg::PROD_W-1:0]    prod_ff;

   // Working results and the output register.
   logic signed [dwo_pkg::OUT_W-1:0] res_ff [dwo_pkg::NUM_RESULTS];
   logic signed [dwo_pkg::OUT_W-1:0] out_ff [dwo_pkg::NUM_RESULTS];

   // Combinational datapath signals.
   logic signed [dwo_pkg::DIFF_W-1:0] dr_raw, dl_raw, dr, dl;
   logic [dwo_pkg::CC_W-1:0]          cc_r, cc_l;
   logic signed [dwo_pkg::OUT_W-1:0]  vr, vl;
   logic signed [dwo_pkg::OPA_W-1:0]  vsum, vdif;
   logic [dwo_pkg::SUM_W-1:0]         smag_r, smag_l;
   logic [dwo_pkg::SUM_W-1:0]         mean_r, mean_l;
   dwo_pkg::op_type                   issue_op, post_op;
   logic                              post_en;
   logic                              post_neg;
   logic [dwo_pkg::RND_W-1:0]         rnd;
   logic signed [dwo_pkg::OUT_W-1:0]  post_val;

   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         right_rev_ff   <= 1'b0;
         left_rev_ff    <= 1'b0;
         vel_per_cnt_ff <= '0;
         rpm_per_cnt_ff <= '0;
         inv_track_ff   <= '0;
         rpm_per_vel_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dwo_pkg::CSR_RIGHT_REV:   right_rev_ff   <= csr_data[0];
            dwo_pkg::CSR_LEFT_REV:    left_rev_ff    <= csr_data[0];
            dwo_pkg::CSR_VEL_PER_CNT: vel_per_cnt_ff <= csr_data;
            dwo_pkg::CSR_RPM_PER_CNT: rpm_per_cnt_ff <= csr_data;
            dwo_pkg::CSR_INV_TRACK:   inv_track_ff   <= csr_data;
            dwo_pkg::CSR_RPM_PER_VEL: rpm_per_vel_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwo_pkg::ST_IDLE;
         step_ff      <= dwo_pkg::STEP_DIFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      copy_out  = 1'b0;
      case (state_ff)
         dwo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = dwo_pkg::ST_RUN;
               step_in  = dwo_pkg::STEP_DIFF;
            end
         end
         dwo_pkg::ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == dwo_pkg::STEP_LAST) begin
               state_in = dwo_pkg::ST_FINISH;
            end
         end
         dwo_pkg::ST_FINISH: begin
            // The output register is free once its word has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               copy_out = 1'b1;
               state_in = dwo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dwo_pkg::ST_IDLE;
         end
      endcase

      if (copy_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ------------------------------------------------------- count difference
   always_comb begin
      dr_raw = DIFF_CAST(cnt_r_ff) - DIFF_CAST(prev_r_ff);
      dl_raw = DIFF_CAST(cnt_l_ff) - DIFF_CAST(prev_l_ff);
      // A difference of exactly half a revolution stays as it is.
      if (dr_raw > dwo_pkg::HALF_S) begin
         dr = dr_raw - dwo_pkg::ENC_S;
      end else if (dr_raw < -dwo_pkg::HALF_S) begin
         dr = dr_raw + dwo_pkg::ENC_S;
      end else begin
         dr = dr_raw;
      end
      if (dl_raw > dwo_pkg::HALF_S) begin
         dl = dl_raw - dwo_pkg::ENC_S;
      end else if (dl_raw < -dwo_pkg::HALF_S) begin
         dl = dl_raw + dwo_pkg::ENC_S;
      end else begin
         dl = dl_raw;
      end
   end

   function automatic logic signed [dwo_pkg::DIFF_W-1:0] DIFF_CAST(
      logic [dwo_pkg::COUNT_W-1:0] c);
      return $signed(dwo_pkg::DIFF_W'(c));
   endfunction

   // ----------------------------------------------- speed sums and window mean
   always_comb begin
      vr     = res_ff[dwo_pkg::SLOT_RIGHT_SPEED];
      vl     = res_ff[dwo_pkg::SLOT_LEFT_SPEED];
      vsum   = dwo_pkg::OPA_W'(vr) + dwo_pkg::OPA_W'(vl);
      vdif   = dwo_pkg::OPA_W'(vr) - dwo_pkg::OPA_W'(vl);
      smag_r = sum_r_ff[dwo_pkg::SUM_W-1] ? dwo_pkg::SUM_W'(-sum_r_ff)
                                          : dwo_pkg::SUM_W'(sum_r_ff);
      smag_l = sum_l_ff[dwo_pkg::SUM_W-1] ? dwo_pkg::SUM_W'(-sum_l_ff)
                                          : dwo_pkg::SUM_W'(sum_l_ff);
      mean_r = (smag_r + dwo_pkg::SUM_W'(dwo_pkg::WINDOW_LENGTH / 2)) >> dwo_pkg::WIN_BITS;
      mean_l = (smag_l + dwo_pkg::SUM_W'(dwo_pkg::WINDOW_LENGTH / 2)) >> dwo_pkg::WIN_BITS;
      cc_r   = right_rev_ff ? dwo_pkg::CC_W'(dwo_pkg::ENCODER_COUNTS) - dwo_pkg::CC_W'(cnt_r_ff)
                            : dwo_pkg::CC_W'(cnt_r_ff);
      cc_l   = left_rev_ff  ? dwo_pkg::CC_W'(dwo_pkg::ENCODER_COUNTS) - dwo_pkg::CC_W'(cnt_l_ff)
                            : dwo_pkg::CC_W'(cnt_l_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_r_ff <= '0;
         prev_l_ff <= '0;
         sum_r_ff  <= '0;
         sum_l_ff  <= '0;
         pos_ff    <= '0;
         for (int i = 0; i < dwo_pkg::WINDOW_LENGTH; i++) begin
            win_r_ff[i] <= '0;
            win_l_ff[i] <= '0;
         end
      end else if (state_ff == dwo_pkg::ST_RUN) begin
         if (step_ff == dwo_pkg::STEP_DIFF) begin
            prev_r_ff <= cnt_r_ff;
            prev_l_ff <= cnt_l_ff;
         end
         if (step_ff == dwo_pkg::STEP_WINDOW) begin
            sum_r_ff <= sum_r_ff + dwo_pkg::SUM_W'(vr) - dwo_pkg::SUM_W'(win_r_ff[pos_ff]);
            sum_l_ff <= sum_l_ff + dwo_pkg::SUM_W'(vl) - dwo_pkg::SUM_W'(win_l_ff[pos_ff]);
            win_r_ff[pos_ff] <= vr;
            win_l_ff[pos_ff] <= vl;
            if (pos_ff == dwo_pkg::WIN_BITS'(dwo_pkg::WINDOW_LENGTH - 1)) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // Operand registers filled ahead of the steps that use them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cnt_r_ff <= req_right_count;
         cnt_l_ff <= req_left_count;
      end
      if (state_ff == dwo_pkg::ST_RUN) begin
         if (step_ff == dwo_pkg::STEP_DIFF) begin
            dmag_r_ff <= dr[dwo_pkg::DIFF_W-1] ? dwo_pkg::COUNT_W'(-dr) : dwo_pkg::COUNT_W'(dr);
            dmag_l_ff <= dl[dwo_pkg::DIFF_W-1] ? dwo_pkg::COUNT_W'(-dl) : dwo_pkg::COUNT_W'(dl);
            neg_r_ff  <= dr[dwo_pkg::DIFF_W-1] ^ right_rev_ff;
            neg_l_ff  <= dl[dwo_pkg::DIFF_W-1] ^ left_rev_ff;
         end
         if (step_ff == dwo_pkg::STEP_WINDOW) begin
            vsum_mag_ff <= vsum[dwo_pkg::OPA_W-1] ? dwo_pkg::OPA_W'(-vsum) : dwo_pkg::OPA_W'(vsum);
            vdif_mag_ff <= vdif[dwo_pkg::OPA_W-1] ? dwo_pkg::OPA_W'(-vdif) : dwo_pkg::OPA_W'(vdif);
            vsum_neg_ff <= vsum[dwo_pkg::OPA_W-1];
            vdif_neg_ff <= vdif[dwo_pkg::OPA_W-1];
         end
         if (step_ff == dwo_pkg::STEP_AVG) begin
            avg_mag_r_ff <= mean_r[dwo_pkg::OUT_W-1:0];
            avg_mag_l_ff <= mean_l[dwo_pkg::OUT_W-1:0];
            avg_neg_r_ff <= sum_r_ff[dwo_pkg::SUM_W-1];
            avg_neg_l_ff <= sum_l_ff[dwo_pkg::SUM_W-1];
         end
      end
   end

   // ------------------------------------------------------ shared multiplier
   always_comb begin
      issue_op = dwo_pkg::op_type'(step_ff - dwo_pkg::STEP_ISSUE);
      mul_a    = '0;
      mul_b    = '0;
      mul_add  = '0;
      case (issue_op)
         dwo_pkg::OP_RIGHT_SPEED: begin
            mul_a = dwo_pkg::OPA_W'(dmag_r_ff);
            mul_b = vel_per_cnt_ff;
         end
         dwo_pkg::OP_LEFT_SPEED: begin
            mul_a = dwo_pkg::OPA_W'(dmag_l_ff);
            mul_b = vel_per_cnt_ff;
         end
         dwo_pkg::OP_RIGHT_RPM: begin
            mul_a = dwo_pkg::OPA_W'(dmag_r_ff);
            mul_b = rpm_per_cnt_ff;
         end
         dwo_pkg::OP_LEFT_RPM: begin
            mul_a = dwo_pkg::OPA_W'(dmag_l_ff);
            mul_b = rpm_per_cnt_ff;
         end
         dwo_pkg::OP_BODY: begin
            mul_a = vsum_mag_ff;
            mul_b = dwo_pkg::OUT_W'(1);
         end
         dwo_pkg::OP_YAW: begin
            mul_a = vdif_mag_ff;
            mul_b = inv_track_ff;
         end
         dwo_pkg::OP_RIGHT_RPM_AVG: begin
            mul_a = dwo_pkg::OPA_W'(avg_mag_r_ff);
            mul_b = rpm_per_vel_ff;
         end
         dwo_pkg::OP_LEFT_RPM_AVG: begin
            mul_a = dwo_pkg::OPA_W'(avg_mag_l_ff);
            mul_b = rpm_per_vel_ff;
         end
         // The upper bits of two pi go in as a small constant product added on.
         dwo_pkg::OP_RIGHT_ANGLE: begin
            mul_a   = dwo_pkg::OPA_W'(cc_r);
            mul_b   = dwo_pkg::ANGLE_LO;
            mul_add = (dwo_pkg::PROD_W'(cc_r) * dwo_pkg::PROD_W'(dwo_pkg::ANGLE_HI)) << 32;
         end
         dwo_pkg::OP_LEFT_ANGLE: begin
            mul_a   = dwo_pkg::OPA_W'(cc_l);
            mul_b   = dwo_pkg::ANGLE_LO;
            mul_add = (dwo_pkg::PROD_W'(cc_l) * dwo_pkg::PROD_W'(dwo_pkg::ANGLE_HI)) << 32;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= dwo_pkg::PROD_W'(mul_a) * dwo_pkg::PROD_W'(mul_b) + mul_add;
   end

   // -------------------------------------------------- rounding and saturation
   always_comb begin
      post_op = dwo_pkg::op_type'(step_ff - dwo_pkg::STEP_POST);
      post_en = (state_ff == dwo_pkg::ST_RUN) && (step_ff >= dwo_pkg::STEP_POST);
      case (post_op)
         dwo_pkg::OP_RIGHT_SPEED, dwo_pkg::OP_RIGHT_RPM: post_neg = neg_r_ff;
         dwo_pkg::OP_LEFT_SPEED, dwo_pkg::OP_LEFT_RPM:   post_neg = neg_l_ff;
         dwo_pkg::OP_BODY:                               post_neg = vsum_neg_ff;
         dwo_pkg::OP_YAW:                                post_neg = vdif_neg_ff;
         dwo_pkg::OP_RIGHT_RPM_AVG:                      post_neg = avg_neg_r_ff;
         dwo_pkg::OP_LEFT_RPM_AVG:                       post_neg = avg_neg_l_ff;
         default:                                        post_neg = 1'b0;
      endcase
      rnd = dwo_pkg::round_mag(post_op, prod_ff);
      if (post_op == dwo_pkg::OP_RIGHT_ANGLE || post_op == dwo_pkg::OP_LEFT_ANGLE) begin
         post_val = dwo_pkg::OUT_W'(rnd[dwo_pkg::ANGLE_W-1:0]);
      end else if (post_neg) begin
         post_val = (rnd >= dwo_pkg::RND_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                               : -rnd[dwo_pkg::OUT_W-1:0];
      end else begin
         post_val = (rnd > dwo_pkg::RND_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                              : rnd[dwo_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (post_en) begin
         res_ff[dwo_pkg::op_slot(post_op)] <= post_val;
      end
      if (state_ff == dwo_pkg::ST_RUN && step_ff == dwo_pkg::STEP_AVG) begin
         res_ff[dwo_pkg::SLOT_RIGHT_AVG] <= sum_r_ff[dwo_pkg::SUM_W-1]
            ? -mean_r[dwo_pkg::OUT_W-1:0] : mean_r[dwo_pkg::OUT_W-1:0];
         res_ff[dwo_pkg::SLOT_LEFT_AVG]  <= sum_l_ff[dwo_pkg::SUM_W-1]
            ? -mean_l[dwo_pkg::OUT_W-1:0] : mean_l[dwo_pkg::OUT_W-1:0];
      end
      if (copy_out) begin
         for (int i = 0; i < dwo_pkg::NUM_RESULTS; i++) begin
            out_ff[i] <= res_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_body_speed      = out_ff[dwo_pkg::SLOT_BODY];
   assign rsp_right_speed     = out_ff[dwo_pkg::SLOT_RIGHT_SPEED];
   assign rsp_left_speed      = out_ff[dwo_pkg::SLOT_LEFT_SPEED];
   assign rsp_right_speed_avg = out_ff[dwo_pkg::SLOT_RIGHT_AVG];
   assign rsp_left_speed_avg  = out_ff[dwo_pkg::SLOT_LEFT_AVG];
   assign rsp_right_rpm       = out_ff[dwo_pkg::SLOT_RIGHT_RPM];
   assign rsp_left_rpm        = out_ff[dwo_pkg::SLOT_LEFT_RPM];
   assign rsp_right_rpm_avg   = out_ff[dwo_pkg::SLOT_RIGHT_RPM_AVG];
   assign rsp_left_rpm_avg    = out_ff[dwo_pkg::SLOT_LEFT_RPM_AVG];
   assign rsp_yaw_rate        = out_ff[dwo_pkg::SLOT_YAW];
   assign rsp_right_angle     = out_ff[dwo_pkg::SLOT_RIGHT_ANGLE][dwo_pkg::ANGLE_W-1:0];
   assign rsp_left_angle      = out_ff[dwo_pkg::SLOT_LEFT_ANGLE][dwo_pkg::ANGLE_W-1:0];

   // ------------------------------------------------------------- assertions
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dwo_pkg::ST_RUN) |-> (step_ff <= dwo_pkg::STEP_LAST))
      else $error("sequencer step ran past the last step");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == dwo_pkg::ST_RUN && step_ff == dwo_pkg::STEP_DIFF))
      else $error("accepted word did not start the sequencer");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dwo_pkg::ST_FINISH))
      else $error("result became valid without a finished word");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == dwo_pkg::ST_RUN && step_ff == dwo_pkg::STEP_WINDOW) |=> $stable(pos_ff))
      else $error("window position moved outside the window step");

endmodule

@@ tb/tb_differential_wheel_odometry.sv @@
// Self-checking testbench for the differential wheel odometry block: directed table, then
// random encoder motion under several register settings, with a built-in predictor.
// Depends on dwo_pkg and differential_wheel_odometry.
module tb_differential_wheel_odometry;
   timeunit 1ns;
   timeprecision 1ps;

   import dwo_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int PHASES          = 9;
   localparam int PHASE_SAMPLES   = 160;
   localparam int DRAIN_CYCLES    = 16;
   localparam int MAX_REPORTS     = 60;

   typedef logic [NUM_RESULTS-1:0][OUT_W-1:0] odo_word_t;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_SAMPLE
   } row_kind_t;

   typedef enum int {
      MOVE_SMOOTH,
      MOVE_FAST,
      MOVE_HALF_TURN,
      MOVE_JUMP,
      MOVE_HOLD
   } motion_t;

   typedef struct packed {
      row_kind_t                kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [OUT_W-1:0]         data;
      logic [COUNT_W-1:0]       right_count;
      logic [COUNT_W-1:0]       left_count;
      logic                     typed;
      logic [ANGLE_W-1:0]       right_angle;
      logic [ANGLE_W-1:0]       left_angle;
   } dir_row_t;

   // Typed rows run while every scale register is zero, so all speeds, rates and
   // averages are zero and only the angles carry information.
   localparam int DIR_ROWS = 25;
   localparam dir_row_t DIRECTED [DIR_ROWS] = '{
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd0, 14'd0, 1'b1, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd16383, 14'd8192, 1'b1, 19'd411750, 19'd205887},
      '{ROW_WRITE, CSR_RIGHT_REV, 32'h0000_0001, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_LEFT_REV, 32'h0000_0003, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd0, 14'd0, 1'b1, 19'd411775, 19'd411775},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd1, 14'd16383, 1'b1, 19'd411750, 19'd25},
      '{ROW_WRITE, CSR_SPARE_LO, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_VEL_PER_CNT, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_RPM_PER_CNT, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_INV_TRACK, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_RPM_PER_VEL, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_SPARE_HI, 32'h0000_0000, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd8193, 14'd8191, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_RIGHT_REV, 32'hFFFF_FFFE, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_LEFT_REV, 32'h0000_0000, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd16383, 14'd1, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd16383, 14'd1, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_VEL_PER_CNT, 32'h0100_0000, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_RPM_PER_CNT, 32'h0000_0001, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_INV_TRACK, 32'h0080_0000, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_WRITE, CSR_RPM_PER_VEL, 32'h3C00_0000, 14'd0, 14'd0, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd100, 14'd16000, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd8292, 14'd7808, 1'b0, 19'd0, 19'd0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 14'd8293, 14'd16001, 1'b0, 19'd0, 19'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [COUNT_W-1:0] req_right_count;
   logic [COUNT_W-1:0] req_left_count;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [OUT_W-1:0] rsp_body_speed;
   logic signed [OUT_W-1:0] rsp_right_speed;
   logic signed [OUT_W-1:0] rsp_left_speed;
   logic signed [OUT_W-1:0] rsp_right_speed_avg;
   logic signed [OUT_W-1:0] rsp_left_speed_avg;
   logic signed [OUT_W-1:0] rsp_right_rpm;
   logic signed [OUT_W-1:0] rsp_left_rpm;
   logic signed [OUT_W-1:0] rsp_right_rpm_avg;
   logic signed [OUT_W-1:0] rsp_left_rpm_avg;
   logic signed [OUT_W-1:0] rsp_yaw_rate;
   logic [ANGLE_W-1:0] rsp_right_angle;
   logic [ANGLE_W-1:0] rsp_left_angle;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [OUT_W-1:0] csr_data;

   // Configuration and state as the predictor sees them.
   logic        cfg_right_rev;
   logic        cfg_left_rev;
   logic [31:0] cfg_vel_per_count;
   logic [31:0] cfg_rpm_per_count;
   logic [31:0] cfg_inv_track;
   logic [31:0] cfg_rpm_per_vel;
   int          last_right_count;
   int          last_left_count;
   int          right_speed_hist [WINDOW_LENGTH];
   int          left_speed_hist [WINDOW_LENGTH];
   longint      right_hist_sum;
   longint      left_hist_sum;
   int          hist_slot;

   odo_word_t   expected_words [$];
   int          fail_count = 0;
   int          samples_sent = 0;
   int          words_checked = 0;
   int          writes_done = 0;
   bit          steady = 1'b0;

   always #1 clock = ~clock;

   differential_wheel_odometry i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_right_count     (req_right_count),
      .req_left_count      (req_left_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_body_speed      (rsp_body_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed_avg (rsp_right_speed_avg),
      .rsp_left_speed_avg  (rsp_left_speed_avg),
      .rsp_right_rpm       (rsp_right_rpm),
      .rsp_left_rpm        (rsp_left_rpm),
      .rsp_right_rpm_avg   (rsp_right_rpm_avg),
      .rsp_left_rpm_avg    (rsp_left_rpm_avg),
      .rsp_yaw_rate        (rsp_yaw_rate),
      .rsp_right_angle     (rsp_right_angle),
      .rsp_left_angle      (rsp_left_angle),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   task automatic odometry_clear();
      cfg_right_rev = 1'b0;
      cfg_left_rev = 1'b0;
      cfg_vel_per_count = '0;
      cfg_rpm_per_count = '0;
      cfg_inv_track = '0;
      cfg_rpm_per_vel = '0;
      last_right_count = 0;
      last_left_count = 0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
         right_speed_hist[i] = 0;
         left_speed_hist[i] = 0;
      end
      right_hist_sum = 0;
      left_hist_sum = 0;
      hist_slot = 0;
   endtask

   function automatic logic [71:0] magnitude(longint v);
      return (v < 0) ? 72'(-v) : 72'(v);
   endfunction

   // Round the magnitude to nearest (ties away from zero), restore the sign, saturate.
   function automatic logic [31:0] round_saturate(bit neg, logic [71:0] mag, int shift);
      logic [71:0] r;
      r = (mag + (72'd1 << (shift - 1))) >> shift;
      if (neg)
         return (r >= 72'h8000_0000) ? 32'h8000_0000 : 32'(72'd0 - r);
      return (r > 72'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
   endfunction

   function automatic int wrapped_delta(int now, int prior);
      int d;
      d = now - prior;
      if (d > ENCODER_COUNTS / 2) d -= ENCODER_COUNTS;
      if (d < -(ENCODER_COUNTS / 2)) d += ENCODER_COUNTS;
      return d;
   endfunction

   function automatic logic [31:0] counts_to_q16(int d, bit rev, logic [31:0] k);
      return round_saturate((d < 0) != rev, magnitude(d) * 72'(k), SPEED_SHIFT);
   endfunction

   function automatic logic [31:0] scale_q16(longint v, logic [31:0] k);
      return round_saturate(v < 0, magnitude(v) * 72'(k), Q24_SHIFT);
   endfunction

   function automatic logic [31:0] window_mean(longint sum);
      logic [71:0] m;
      m = (magnitude(sum) + 72'(WINDOW_LENGTH / 2)) / 72'(WINDOW_LENGTH);
      return (sum < 0) ? 32'(72'd0 - m) : m[31:0];
   endfunction

   function automatic logic [31:0] angle_radians(int c, bit rev);
      logic [63:0] turns;
      logic [63:0] span;
      turns = rev ? 64'(ENCODER_COUNTS - c) : 64'(c);
      span = 64'(ENCODER_COUNTS) << 16;
      return 32'(((turns * 64'(TWO_PI_Q32) + span / 2) / span) & 64'h7FFFF);
   endfunction

   function automatic odo_word_t odometry_predict(logic [COUNT_W-1:0] rc,
                                                   logic [COUNT_W-1:0] lc);
      odo_word_t w;
      int dr;
      int dl;
      logic [31:0] vr;
      logic [31:0] vl;
      logic [31:0] avg_r;
      logic [31:0] avg_l;
      longint both;
      dr = wrapped_delta(int'(rc), last_right_count);
      dl = wrapped_delta(int'(lc), last_left_count);
      last_right_count = int'(rc);
      last_left_count = int'(lc);
      vr = counts_to_q16(dr, cfg_right_rev, cfg_vel_per_count);
      vl = counts_to_q16(dl, cfg_left_rev, cfg_vel_per_count);
      both = longint'($signed(vr)) + longint'($signed(vl));
      right_hist_sum += longint'($signed(vr)) - longint'(right_speed_hist[hist_slot]);
      left_hist_sum += longint'($signed(vl)) - longint'(left_speed_hist[hist_slot]);
      right_speed_hist[hist_slot] = $signed(vr);
      left_speed_hist[hist_slot] = $signed(vl);
      hist_slot = (hist_slot + 1) % WINDOW_LENGTH;
      avg_r = window_mean(right_hist_sum);
      avg_l = window_mean(left_hist_sum);
      w = '0;
      w[SLOT_BODY] = round_saturate(both < 0, magnitude(both), BODY_SHIFT);
      w[SLOT_RIGHT_SPEED] = vr;
      w[SLOT_LEFT_SPEED] = vl;
      w[SLOT_RIGHT_AVG] = avg_r;
      w[SLOT_LEFT_AVG] = avg_l;
      w[SLOT_RIGHT_RPM] = counts_to_q16(dr, cfg_right_rev, cfg_rpm_per_count);
      w[SLOT_LEFT_RPM] = counts_to_q16(dl, cfg_left_rev, cfg_rpm_per_count);
      w[SLOT_RIGHT_RPM_AVG] = scale_q16(longint'($signed(avg_r)), cfg_rpm_per_vel);
      w[SLOT_LEFT_RPM_AVG] = scale_q16(longint'($signed(avg_l)), cfg_rpm_per_vel);
      w[SLOT_YAW] = scale_q16(longint'($signed(vr)) - longint'($signed(vl)), cfg_inv_track);
      w[SLOT_RIGHT_ANGLE] = angle_radians(int'(rc), cfg_right_rev);
      w[SLOT_LEFT_ANGLE] = angle_radians(int'(lc), cfg_left_rev);
      return w;
   endfunction

   function automatic string slot_label(int slot);
      case (slot)
         SLOT_BODY:          return "body_speed";
         SLOT_RIGHT_SPEED:   return "right_speed";
         SLOT_LEFT_SPEED:    return "left_speed";
         SLOT_RIGHT_AVG:     return "right_speed_avg";
         SLOT_LEFT_AVG:      return "left_speed_avg";
         SLOT_RIGHT_RPM:     return "right_rpm";
         SLOT_LEFT_RPM:      return "left_rpm";
         SLOT_RIGHT_RPM_AVG: return "right_rpm_avg";
         SLOT_LEFT_RPM_AVG:  return "left_rpm_avg";
         SLOT_YAW:           return "yaw_rate";
         SLOT_RIGHT_ANGLE:   return "right_angle";
         default:            return "left_angle";
      endcase
   endfunction

   // Mostly short gaps, now and then a long one; none while running steady.
   function automatic int pick_pause();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_factor();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         3:       return $urandom_range(0, 32'h0001_0000);
         4:       return $urandom_range(32'h0010_0000, 32'h0400_0000);
         default: return 32'h0100_0000;
      endcase
   endfunction

   function automatic int step_position(int pos, motion_t how);
      int delta;
      case (how)
         MOVE_SMOOTH:    delta = int'($urandom_range(0, 600)) - 300;
         MOVE_FAST:      delta = int'($urandom_range(0, ENCODER_COUNTS)) - ENCODER_COUNTS / 2;
         MOVE_HALF_TURN: delta = $urandom_range(0, 1) ? ENCODER_COUNTS / 2
                                                      : -(ENCODER_COUNTS / 2);
         MOVE_JUMP:      return $urandom_range(0, ENCODER_COUNTS - 1);
         default:        delta = 0;
      endcase
      return (pos + delta + ENCODER_COUNTS) % ENCODER_COUNTS;
   endfunction

   // Drops the request valid and waits for every outstanding word to come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      hold_until_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RIGHT_REV:   cfg_right_rev = data[0];
         CSR_LEFT_REV:    cfg_left_rev = data[0];
         CSR_VEL_PER_CNT: cfg_vel_per_count = data;
         CSR_RPM_PER_CNT: cfg_rpm_per_count = data;
         CSR_INV_TRACK:   cfg_inv_track = data;
         CSR_RPM_PER_VEL: cfg_rpm_per_vel = data;
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drive_sample(logic [COUNT_W-1:0] rc, logic [COUNT_W-1:0] lc,
                               bit typed, odo_word_t typed_word);
      int gap;
      odo_word_t predicted;
      gap = pick_pause();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_right_count = rc;
      req_left_count = lc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = odometry_predict(rc, lc);
      expected_words.push_back(typed ? typed_word : predicted);
      samples_sent++;
   endtask

   task automatic apply_setting(int phase);
      if (phase == 0) begin
         csr_write(CSR_VEL_PER_CNT, 32'hFFFF_FFFF);
         csr_write(CSR_RPM_PER_CNT, 32'hFFFF_FFFF);
         csr_write(CSR_INV_TRACK, 32'hFFFF_FFFF);
         csr_write(CSR_RPM_PER_VEL, 32'hFFFF_FFFF);
      end else if (phase == 1) begin
         csr_write(CSR_VEL_PER_CNT, 32'h0);
         csr_write(CSR_RPM_PER_CNT, 32'h0);
         csr_write(CSR_INV_TRACK, 32'h0);
         csr_write(CSR_RPM_PER_VEL, 32'h0);
      end else begin
         csr_write(CSR_VEL_PER_CNT, pick_factor());
         csr_write(CSR_RPM_PER_CNT, pick_factor());
         csr_write(CSR_INV_TRACK, pick_factor());
         csr_write(CSR_RPM_PER_VEL, pick_factor());
      end
      // Upper data bits are random so that only bit 0 may matter for the flags.
      csr_write(CSR_RIGHT_REV, $urandom());
      csr_write(CSR_LEFT_REV, $urandom());
      if ($urandom_range(0, 2) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
   endtask

   initial begin
      int rsp_hold;
      rsp_hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_ready = 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_hold = pick_pause();
            rsp_ready = (rsp_hold == 0);
         end
      end
   end

   always @(posedge clock) begin
      odo_word_t got;
      odo_word_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got[SLOT_BODY] = rsp_body_speed;
         got[SLOT_RIGHT_SPEED] = rsp_right_speed;
         got[SLOT_LEFT_SPEED] = rsp_left_speed;
         got[SLOT_RIGHT_AVG] = rsp_right_speed_avg;
         got[SLOT_LEFT_AVG] = rsp_left_speed_avg;
         got[SLOT_RIGHT_RPM] = rsp_right_rpm;
         got[SLOT_LEFT_RPM] = rsp_left_rpm;
         got[SLOT_RIGHT_RPM_AVG] = rsp_right_rpm_avg;
         got[SLOT_LEFT_RPM_AVG] = rsp_left_rpm_avg;
         got[SLOT_YAW] = rsp_yaw_rate;
         got[SLOT_RIGHT_ANGLE] = 32'(rsp_right_angle);
         got[SLOT_LEFT_ANGLE] = 32'(rsp_left_angle);
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t ns: result word with none expected, body_speed %0d",
                        $time, $signed(got[SLOT_BODY]));
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            for (int s = 0; s < NUM_RESULTS; s++) begin
               if (got[s] !== want[s]) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t ns: %s expected %0d, got %0d", $time, slot_label(s),
                              $signed(want[s]), $signed(got[s]));
               end
            end
         end
      end
   end

   initial begin
      odo_word_t typed_word;
      dir_row_t row;
      int right_pos;
      int left_pos;
      int roll;
      motion_t how;

      odometry_clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_right_count = '0;
      req_left_count = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_WRITE) begin
            csr_write(row.index, row.data);
         end else begin
            typed_word = '0;
            typed_word[SLOT_RIGHT_ANGLE] = 32'(row.right_angle);
            typed_word[SLOT_LEFT_ANGLE] = 32'(row.left_angle);
            drive_sample(row.right_count, row.left_count, row.typed, typed_word);
         end
      end

      right_pos = last_right_count;
      left_pos = last_left_count;
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_setting(phase);
         steady = (phase == 3);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            // The sender stops once per phase until every word has come back.
            if (n == PHASE_SAMPLES / 2) hold_until_drained();
            roll = $urandom_range(0, 99);
            if (roll < 72) how = MOVE_SMOOTH;
            else if (roll < 84) how = MOVE_FAST;
            else if (roll < 90) how = MOVE_HALF_TURN;
            else if (roll < 96) how = MOVE_JUMP;
            else how = MOVE_HOLD;
            right_pos = step_position(right_pos, how);
            left_pos = step_position(left_pos, ($urandom_range(0, 3) == 0) ? MOVE_JUMP : how);
            drive_sample(COUNT_W'(right_pos), COUNT_W'(left_pos), 1'b0, '0);
         end
         steady = 1'b0;
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d encoder samples through %0d register settings (%0d writes),",
               samples_sent, PHASES + 1, writes_done);
      $display("checked %0d result words field by field, %0d mismatches.",
               words_checked, fail_count);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d words still outstanding.", expected_words.size());
      $display("status: fail");
      $finish;
   end

endmodule
